/* hw/rtl/pcpp_pkg.sv */
// Shared constants, codes and types of the promotable priority queue.
package pcpp_pkg;

	// Default sizes of the table
	localparam int unsigned CAPACITY_DEF       = 256;
	localparam int unsigned DATA_WIDTH_DEF     = 32;
	localparam int unsigned PRIORITY_WIDTH_DEF = 16;

	// Fixed widths of the channel fields
	localparam int unsigned OP_W     = 3;
	localparam int unsigned ID_W     = 8;
	localparam int unsigned PAYLD_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned RDATA_W  = 32;
	localparam int unsigned RPRIO_W  = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
	localparam logic [OP_W-1:0] OP_PROMOTE = 3'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
	localparam logic [OP_W-1:0] OP_POP     = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LOOKUP,
		S_SCAN,
		S_SCAN_END,
		S_FETCH,
		S_FETCH2,
		S_RESP
	} state_t;

endpackage

/* hw/rtl/pcpp_in_if.sv */
// Request channel of the priority queue: valid/ready handshake and operation fields.
interface pcpp_in_if;
	logic                         valid;
	logic                         ready;
	logic [pcpp_pkg::OP_W-1:0]    op;
	logic [pcpp_pkg::ID_W-1:0]    entry_id;
	logic [pcpp_pkg::PAYLD_W-1:0] payload;

	modport source (output valid, output op, output entry_id, output payload, input ready);
	modport sink (input valid, input op, input entry_id, input payload, output ready);
endinterface

/* hw/rtl/pcpp_out_if.sv */
// Response channel of the priority queue: valid/ready handshake and result fields.
interface pcpp_out_if;
	logic                          valid;
	logic                          ready;
	logic [pcpp_pkg::STATUS_W-1:0] status;
	logic                          is_live;
	logic [pcpp_pkg::ID_W-1:0]     result_id;
	logic [pcpp_pkg::RDATA_W-1:0]  result_data;
	logic [pcpp_pkg::RPRIO_W-1:0]  result_priority;

	modport source (output valid, output status, output is_live, output result_id,
		output result_data, output result_priority, input ready);
	modport sink (input valid, input status, input is_live, input result_id,
		input result_data, input result_priority, output ready);
endinterface

/* hw/rtl/pcpp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcpp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/priority_collection_promote_pop.sv */
// Top level of the promotable max-priority queue with its scan sequencer.
//
// Usage: requests arrive on req (op, entry_id, payload) and every request
// produces exactly one response on rsp (status, is_live, result_id,
// result_data, result_priority). Both channels use valid/ready and a transfer
// happens on a clock edge where both are high. The block works on one request
// at a time: req.ready is high only while the sequencer is idle.
// Add, an unknown op and any request rejected up front are answered from the execute
// state; promote and query first read the entry; peek and pop scan, as one priority
// comparator walks every slot ever allocated, one RAM read per cycle, and then fetch
// the winner. A new request can be taken in the cycle after the response is loaded.
// Entry data and priorities live in two RAMs. Liveness needs no per-entry
// reset: a slot is live only if it lies below the allocation count and its
// live flag, written with the priority, is set. Reset therefore takes effect
// at once, with no clearing pass: the count returns to zero and the queue is
// empty. When the receiver stalls, the response stays in the output register
// and the block still takes the next request; that request is finished into
// a holding register and waits until the output register is free.
module priority_collection_promote_pop #(
	parameter int unsigned CAPACITY       = pcpp_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH     = pcpp_pkg::DATA_WIDTH_DEF,
	parameter int unsigned PRIORITY_WIDTH = pcpp_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pcpp_in_if.sink           req,
	pcpp_out_if.source        rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = AW + 1;
	// Priority RAM word: live flag on top of the priority.
	localparam int unsigned PW = PRIORITY_WIDTH + 1;

	pcpp_pkg::state_t state_q, state_d;

	// Latched request
	logic [pcpp_pkg::OP_W-1:0]  op_q;
	logic [pcpp_pkg::ID_W-1:0]  id_q;
	logic [DATA_WIDTH-1:0]      payload_q;

	// Allocation count and scan state
	logic [CW-1:0]             next_free_q;
	logic [AW-1:0]             scan_q;
	logic [AW-1:0]             last_idx;
	logic                      cmp_vld_s1;
	logic [AW-1:0]             cmp_idx_s1;
	logic                      found_q;
	logic [AW-1:0]             best_q;
	logic [PRIORITY_WIDTH-1:0] best_prio_q;

	// RAM ports
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic                  prio_we;
	logic [PW-1:0]         prio_wdata;
	logic [PW-1:0]         prio_rdata;
	logic                  data_we;
	logic [DATA_WIDTH-1:0] data_rdata;

	logic                      rd_live;
	logic [PRIORITY_WIDTH-1:0] rd_prio;
	logic [PRIORITY_WIDTH-1:0] prio_inc;

	// Finished result waiting for the output register
	logic                          res_ld;
	logic [pcpp_pkg::STATUS_W-1:0] res_status_d, res_status_q;
	logic                          res_live_d, res_live_q;
	logic [pcpp_pkg::ID_W-1:0]     res_id_d, res_id_q;
	logic [pcpp_pkg::RDATA_W-1:0]  res_data_d, res_data_q;
	logic [pcpp_pkg::RPRIO_W-1:0]  res_prio_d, res_prio_q;

	// Output register
	logic                          rsp_vld_q;
	logic                          rsp_ld;
	logic [pcpp_pkg::STATUS_W-1:0] rsp_status_q;
	logic                          rsp_live_q;
	logic [pcpp_pkg::ID_W-1:0]     rsp_id_q;
	logic [pcpp_pkg::RDATA_W-1:0]  rsp_data_q;
	logic [pcpp_pkg::RPRIO_W-1:0]  rsp_prio_q;

	logic accept;
	logic full;
	logic id_ok;

	assign accept   = req.valid && req.ready;
	assign full     = (next_free_q == CW'(CAPACITY));
	// Ids map directly onto slots, and only slots below the count were written.
	assign id_ok    = (32'(id_q) < 32'(next_free_q));
	assign last_idx = AW'(next_free_q - CW'(1));
	assign rd_live  = prio_rdata[PW-1];
	assign rd_prio  = prio_rdata[PRIORITY_WIDTH-1:0];
	// Promotion saturates at the largest priority.
	assign prio_inc = (rd_prio == '1) ? rd_prio : rd_prio + PRIORITY_WIDTH'(1);

	pcpp_ram #(
		.WIDTH (PW),
		.DEPTH (CAPACITY)
	) u_prio_ram (
		.clk   (clk),
		.we    (prio_we),
		.waddr (wr_addr),
		.wdata (prio_wdata),
		.raddr (rd_addr),
		.rdata (prio_rdata)
	);

	pcpp_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (wr_addr),
		.wdata (payload_q),
		.raddr (rd_addr),
		.rdata (data_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, RAM controls and the finished result.
	always_comb begin
		state_d      = state_q;
		rd_addr      = best_q;
		wr_addr      = best_q;
		prio_we      = 1'b0;
		prio_wdata   = {1'b0, best_prio_q};
		data_we      = 1'b0;
		res_ld       = 1'b0;
		res_status_d = pcpp_pkg::ST_OK;
		res_live_d   = 1'b0;
		res_id_d     = '0;
		res_data_d   = '0;
		res_prio_d   = '0;
		rsp_ld       = 1'b0;

		unique case (state_q)
			pcpp_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = pcpp_pkg::S_EXEC;
				end
			end
			pcpp_pkg::S_EXEC: begin
				unique case (op_q)
					pcpp_pkg::OP_ADD: begin
						res_ld  = 1'b1;
						state_d = pcpp_pkg::S_RESP;
						if (full) begin
							res_status_d = pcpp_pkg::ST_FULL;
						end else begin
							// New entry: live, priority zero.
							wr_addr    = AW'(next_free_q);
							data_we    = 1'b1;
							prio_we    = 1'b1;
							prio_wdata = {1'b1, {PRIORITY_WIDTH{1'b0}}};
							res_id_d   = pcpp_pkg::ID_W'(next_free_q);
						end
					end
					pcpp_pkg::OP_PROMOTE, pcpp_pkg::OP_QUERY: begin
						if (!id_ok) begin
							res_ld       = 1'b1;
							res_status_d = pcpp_pkg::ST_BAD_ID;
							state_d      = pcpp_pkg::S_RESP;
						end else begin
							rd_addr = AW'(id_q);
							state_d = pcpp_pkg::S_LOOKUP;
						end
					end
					pcpp_pkg::OP_PEEK, pcpp_pkg::OP_POP: begin
						if (next_free_q == '0) begin
							res_ld       = 1'b1;
							res_status_d = pcpp_pkg::ST_EMPTY;
							state_d      = pcpp_pkg::S_RESP;
						end else begin
							state_d = pcpp_pkg::S_SCAN;
						end
					end
					default: begin
						// Unknown operation: all-zero response.
						res_ld  = 1'b1;
						state_d = pcpp_pkg::S_RESP;
					end
				endcase
			end
			pcpp_pkg::S_LOOKUP: begin
				res_ld  = 1'b1;
				state_d = pcpp_pkg::S_RESP;
				if (!rd_live) begin
					res_status_d = pcpp_pkg::ST_BAD_ID;
				end else begin
					res_id_d   = id_q;
					res_data_d = pcpp_pkg::RDATA_W'(data_rdata);
					if (op_q == pcpp_pkg::OP_PROMOTE) begin
						wr_addr    = AW'(id_q);
						prio_we    = 1'b1;
						prio_wdata = {1'b1, prio_inc};
						res_prio_d = pcpp_pkg::RPRIO_W'(prio_inc);
					end else begin
						res_live_d = 1'b1;
						res_prio_d = pcpp_pkg::RPRIO_W'(rd_prio);
					end
				end
			end
			pcpp_pkg::S_SCAN: begin
				rd_addr = scan_q;
				if (scan_q == last_idx) begin
					state_d = pcpp_pkg::S_SCAN_END;
				end
			end
			pcpp_pkg::S_SCAN_END: begin
				// The last slot is compared during this cycle.
				state_d = pcpp_pkg::S_FETCH;
			end
			pcpp_pkg::S_FETCH: begin
				rd_addr = best_q;
				if (!found_q) begin
					res_ld       = 1'b1;
					res_status_d = pcpp_pkg::ST_EMPTY;
					state_d      = pcpp_pkg::S_RESP;
				end else begin
					state_d = pcpp_pkg::S_FETCH2;
				end
			end
			pcpp_pkg::S_FETCH2: begin
				res_ld     = 1'b1;
				res_id_d   = pcpp_pkg::ID_W'(best_q);
				res_data_d = pcpp_pkg::RDATA_W'(data_rdata);
				res_prio_d = pcpp_pkg::RPRIO_W'(best_prio_q);
				state_d    = pcpp_pkg::S_RESP;
				if (op_q == pcpp_pkg::OP_POP) begin
					// Retire the entry by clearing its live flag.
					prio_we = 1'b1;
				end
			end
			pcpp_pkg::S_RESP: begin
				if (!rsp_vld_q || rsp.ready) begin
					rsp_ld  = 1'b1;
					state_d = pcpp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pcpp_pkg::S_IDLE;
			end
		endcase
	end

	assign req.ready = (state_q == pcpp_pkg::S_IDLE);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.op;
			id_q      <= req.entry_id;
			payload_q <= DATA_WIDTH'(req.payload);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
		end else if (data_we) begin
			next_free_q <= next_free_q + CW'(1);
		end
	end

	// Scan: one slot read per cycle, compared in the next cycle when the RAM
	// data arrives. Using >= while walking upward hands ties to the higher id.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == pcpp_pkg::S_SCAN);
			cmp_idx_s1 <= scan_q;
			if (state_q == pcpp_pkg::S_EXEC) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == pcpp_pkg::S_SCAN) begin
				scan_q <= scan_q + AW'(1);
			end
			if (cmp_vld_s1 && rd_live && (!found_q || rd_prio >= best_prio_q)) begin
				found_q <= 1'b1;
				best_q  <= cmp_idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && rd_live && (!found_q || rd_prio >= best_prio_q)) begin
			best_prio_q <= rd_prio;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_live_q   <= res_live_d;
			res_id_q     <= res_id_d;
			res_data_q   <= res_data_d;
			res_prio_q   <= res_prio_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_ld) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ld) begin
			rsp_status_q <= res_status_q;
			rsp_live_q   <= res_live_q;
			rsp_id_q     <= res_id_q;
			rsp_data_q   <= res_data_q;
			rsp_prio_q   <= res_prio_q;
		end
	end

	assign rsp.valid           = rsp_vld_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.is_live         = rsp_live_q;
	assign rsp.result_id       = rsp_id_q;
	assign rsp.result_data     = rsp_data_q;
	assign rsp.result_priority = rsp_prio_q;

endmodule

/* hw/rtl/pcpp_checker.sv */
// Port-level assertions for the priority queue and their binding to the top level.
module pcpp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [pcpp_pkg::STATUS_W-1:0] rsp_status,
	input logic                          rsp_is_live,
	input logic [pcpp_pkg::ID_W-1:0]     rsp_result_id,
	input logic [pcpp_pkg::RDATA_W-1:0]  rsp_result_data,
	input logic [pcpp_pkg::RPRIO_W-1:0]  rsp_result_priority
);

	// A stalled response keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_result_id) && $stable(rsp_result_data)
			&& $stable(rsp_result_priority))
		else $error("stalled response changed");

	// One request at a time: the block is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a previous one is in progress");

	// Error responses carry no entry information.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != pcpp_pkg::ST_OK |-> !rsp_is_live
			&& rsp_result_id == '0 && rsp_result_data == '0
			&& rsp_result_priority == '0)
		else $error("error response carries entry fields");

	// Only a successful query reports a live entry.
	a_live_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_live |-> rsp_status == pcpp_pkg::ST_OK)
		else $error("live flag set on a failed response");

endmodule

bind priority_collection_promote_pop pcpp_checker u_pcpp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_is_live         (rsp.is_live),
	.rsp_result_id       (rsp.result_id),
	.rsp_result_data     (rsp.result_data),
	.rsp_result_priority (rsp.result_priority)
);

/* sim/priority_collection_promote_pop_tb.sv */
// Self-checking testbench of the promotable max-priority queue, with its own prediction.
`timescale 1ns / 1ps

module priority_collection_promote_pop_tb;
	import pcpp_pkg::*;

	// Op codes 5 to 7 are not defined. The block must answer them with an all-zero response.
	localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

	localparam int unsigned ID_MAX       = (1 << ID_W) - 1;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned LONG_STALL   = 600;

	// Lengths of the random phases.
	localparam int unsigned GROW_ITEMS    = 60;
	localparam int unsigned PROMOTE_BURST = 16;
	localparam int unsigned FULL_EXTRA    = 16;
	localparam int unsigned DRAIN_ITEMS   = 30;

	// One response of the block, field for field as it appears on the response channel.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                is_live;
		logic [ID_W-1:0]     id;
		logic [RDATA_W-1:0]  data;
		logic [RPRIO_W-1:0]  prio;
	} resp_t;

	localparam resp_t RSP_ZERO = '0;

	// A row of the directed part. Where known is set, the response is typed into the row.
	// Otherwise the predicted response is used.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [ID_W-1:0]    id;
		logic [PAYLD_W-1:0] payload;
		logic               known;
		resp_t              known_rsp;
	} directed_row_t;

	// Relative weights of the operations in a stretch of random requests.
	typedef struct packed {
		byte unsigned add;
		byte unsigned promote;
		byte unsigned query;
		byte unsigned peek;
		byte unsigned pop;
		byte unsigned rsvd;
	} op_mix_t;

	localparam op_mix_t MIX_GROW  = '{8'd35, 8'd25, 8'd15, 8'd8, 8'd10, 8'd7};
	localparam op_mix_t MIX_FILL  = '{8'd80, 8'd6, 8'd5, 8'd3, 8'd3, 8'd3};
	localparam op_mix_t MIX_DRAIN = '{8'd8, 8'd20, 8'd15, 8'd10, 8'd42, 8'd5};

	localparam int DIRECTED_ROWS = 25;

	// The directed part starts from an empty table. It covers the empty table, ids that were
	// never assigned or were already popped, the reserved op codes, the tie rule of peek
	// (the highest id wins) and data words at both extremes.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_PEEK,     8'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_POP,      8'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_QUERY,    8'd0,   32'd0,         1'b1, '{ST_BAD_ID, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_PROMOTE,  8'd255, 32'd0,         1'b1, '{ST_BAD_ID, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_RSVD_LO,  8'd255, 32'hFFFF_FFFF, 1'b1, RSP_ZERO},
		'{OP_ADD,      8'd0,   32'd0,         1'b1, '{ST_OK, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_ADD,      8'd255, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 1'b0, 8'd1, 32'd0, 16'd0}},
		'{OP_ADD,      8'd17,  32'hA5A5_5A5A, 1'b1, '{ST_OK, 1'b0, 8'd2, 32'd0, 16'd0}},
		'{OP_QUERY,    8'd1,   32'd0,         1'b1,
			'{ST_OK, 1'b1, 8'd1, 32'hFFFF_FFFF, 16'd0}},
		'{OP_QUERY,    8'd3,   32'd0,         1'b1, '{ST_BAD_ID, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_PROMOTE,  8'd0,   32'hFFFF_FFFF, 1'b1, '{ST_OK, 1'b0, 8'd0, 32'd0, 16'd1}},
		'{OP_PEEK,     8'd0,   32'd0,         1'b1, '{ST_OK, 1'b0, 8'd0, 32'd0, 16'd1}},
		'{OP_PROMOTE,  8'd2,   32'd0,         1'b1,
			'{ST_OK, 1'b0, 8'd2, 32'hA5A5_5A5A, 16'd1}},
		'{OP_PEEK,     8'd128, 32'd0,         1'b0, RSP_ZERO},
		'{OP_POP,      8'd0,   32'd0,         1'b0, RSP_ZERO},
		'{OP_QUERY,    8'd2,   32'd0,         1'b1, '{ST_BAD_ID, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_PROMOTE,  8'd2,   32'd0,         1'b1, '{ST_BAD_ID, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_RSVD_MID, 8'd1,   32'h8000_0001, 1'b1, RSP_ZERO},
		'{OP_RSVD_HI,  8'd0,   32'd0,         1'b1, RSP_ZERO},
		'{OP_POP,      8'd0,   32'd0,         1'b0, RSP_ZERO},
		'{OP_PEEK,     8'd0,   32'd0,         1'b0, RSP_ZERO},
		'{OP_POP,      8'd0,   32'd0,         1'b0, RSP_ZERO},
		'{OP_POP,      8'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 8'd0, 32'd0, 16'd0}},
		'{OP_ADD,      8'd0,   32'h1234_5678, 1'b1, '{ST_OK, 1'b0, 8'd3, 32'd0, 16'd0}},
		'{OP_QUERY,    8'd3,   32'd0,         1'b0, RSP_ZERO}
	};

	logic clk = 1'b0;
	logic arst_n;

	pcpp_in_if  req_ch ();
	pcpp_out_if rsp_ch ();

	priority_collection_promote_pop DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The predicted contents of the table. The data and priority words are only read for live
	// slots, so they need no reset value.
	logic [RDATA_W-1:0]            tbl_data  [CAPACITY_DEF];
	logic [PRIORITY_WIDTH_DEF-1:0] tbl_prio  [CAPACITY_DEF];
	bit                            tbl_live  [CAPACITY_DEF];
	int unsigned                   tbl_next_id;
	int unsigned                   tbl_live_count;

	// Responses owed by the block, oldest first.
	resp_t pending_responses [$];

	int unsigned mismatch_count;
	int unsigned stall_request;
	bit          idling_on;

	// Apply one accepted request to the predicted table and return the response that it owes.
	function automatic resp_t predict_response(input logic [OP_W-1:0] op,
			input logic [ID_W-1:0] id, input logic [PAYLD_W-1:0] payload);
		resp_t r;
		bit    found;
		int    best;
		r = '0;
		case (op)
			OP_ADD: begin
				// Ids are never handed out twice, so once the count reaches the end of the
				// table every add is refused, even with retired slots in it.
				if (tbl_next_id >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					tbl_data[tbl_next_id] = payload;
					tbl_prio[tbl_next_id] = '0;
					tbl_live[tbl_next_id] = 1'b1;
					r.id = ID_W'(tbl_next_id);
					tbl_next_id++;
					tbl_live_count++;
				end
			end
			OP_PROMOTE: begin
				if (!tbl_live[id]) begin
					r.status = ST_BAD_ID;
				end else begin
					// The priority saturates at its maximum. The promote still succeeds.
					if (tbl_prio[id] != '1)
						tbl_prio[id] = tbl_prio[id] + 1'b1;
					r.id   = id;
					r.data = tbl_data[id];
					r.prio = tbl_prio[id];
				end
			end
			OP_QUERY: begin
				if (!tbl_live[id]) begin
					r.status = ST_BAD_ID;
				end else begin
					r.is_live = 1'b1;
					r.id      = id;
					r.data    = tbl_data[id];
					r.prio    = tbl_prio[id];
				end
			end
			OP_PEEK, OP_POP: begin
				// The scan keeps the later slot on equal priority, so ties go to the highest id.
				found = 1'b0;
				best  = 0;
				for (int i = 0; i < CAPACITY_DEF; i++) begin
					if (tbl_live[i] && (!found || tbl_prio[i] >= tbl_prio[best])) begin
						best  = i;
						found = 1'b1;
					end
				end
				if (!found) begin
					r.status = ST_EMPTY;
				end else begin
					r.id   = ID_W'(best);
					r.data = tbl_data[best];
					r.prio = tbl_prio[best];
					if (op == OP_POP) begin
						tbl_live[best] = 1'b0;
						tbl_live_count--;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offer one request and hold it until the block takes it, then record what it owes.
	// Valid is left high on return. The caller either offers the next request in the same
	// time step or lowers valid through wait_drained.
	task automatic issue_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [PAYLD_W-1:0] payload, input logic known, input resp_t known_rsp);
		resp_t predicted;
		if (idling_on && $urandom_range(3, 0) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(7, 1)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.entry_id <= id;
		req_ch.payload  <= payload;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		// The prediction always runs, so that the table stays in step on typed rows too.
		predicted = predict_response(op, id, payload);
		pending_responses.insert(pending_responses.size(), known ? known_rsp : predicted);
	endtask

	// One random request drawn from an operation mix. Most ids name slots that were handed
	// out, so promote and query reach live entries. The rest span the whole id range.
	task automatic issue_random(input op_mix_t mix);
		int unsigned        pick;
		int unsigned        total;
		logic [OP_W-1:0]    op;
		logic [ID_W-1:0]    id;
		logic [PAYLD_W-1:0] payload;
		total = mix.add + mix.promote + mix.query + mix.peek + mix.pop + mix.rsvd;
		pick  = $urandom_range(total - 1, 0);
		if (pick < mix.add)
			op = OP_ADD;
		else if (pick < mix.add + mix.promote)
			op = OP_PROMOTE;
		else if (pick < mix.add + mix.promote + mix.query)
			op = OP_QUERY;
		else if (pick < mix.add + mix.promote + mix.query + mix.peek)
			op = OP_PEEK;
		else if (pick < mix.add + mix.promote + mix.query + mix.peek + mix.pop)
			op = OP_POP;
		else
			op = OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
		if (tbl_next_id != 0 && $urandom_range(9, 0) < 8)
			id = ID_W'($urandom_range(tbl_next_id - 1, 0));
		else
			id = ID_W'($urandom_range(ID_MAX, 0));
		case ($urandom_range(7, 0))
			0:       payload = '0;
			1:       payload = '1;
			default: payload = $urandom();
		endcase
		issue_request(op, id, payload, 1'b0, RSP_ZERO);
	endtask

	// Stop offering requests and wait until every owed response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_failure(input string what, input resp_t want, input resp_t got);
		string expected_text;
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			expected_text = $sformatf("status=%0d live=%0d id=%0d data=%h prio=%0d",
				want.status, want.is_live, want.id, want.data, want.prio);
			$display("%0t ns: %s: expected %s, got status=%0d live=%0d id=%0d data=%h prio=%0d",
				$time, what, expected_text, got.status, got.is_live, got.id, got.data,
				got.prio);
		end
	endtask

	// The receiving side. It checks each accepted response against the oldest one owed,
	// then decides ready for the next cycle. A long stall from the stimulus comes first,
	// then random stall bursts while idling is on.
	initial begin
		int unsigned stall_left;
		int unsigned burst_left;
		logic        next_ready;
		resp_t       got;
		resp_t       want;
		stall_left = 0;
		burst_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.status  = rsp_ch.status;
				got.is_live = rsp_ch.is_live;
				got.id      = rsp_ch.result_id;
				got.data    = rsp_ch.result_data;
				got.prio    = rsp_ch.result_priority;
				if (pending_responses.size() == 0) begin
					report_failure("response with no request outstanding", RSP_ZERO, got);
				end else begin
					want = pending_responses.pop_front();
					if (got.status !== want.status || got.is_live !== want.is_live ||
							got.id !== want.id || got.data !== want.data ||
							got.prio !== want.prio)
						report_failure("response mismatch", want, got);
				end
			end
			if (stall_request != 0) begin
				stall_left    = stall_request;
				stall_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (burst_left != 0) begin
				burst_left--;
				next_ready = 1'b0;
			end else if (idling_on && $urandom_range(5, 0) == 0) begin
				burst_left = $urandom_range(7, 1) - 1;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			rsp_ch.ready <= next_ready;
		end
	end

	// Stimulus, phase by phase.
	initial begin
		logic [ID_W-1:0] hot_id;
		req_ch.valid    <= 1'b0;
		req_ch.op       <= OP_ADD;
		req_ch.entry_id <= '0;
		req_ch.payload  <= '0;
		arst_n          <= 1'b0;
		idling_on       = 1'b1;
		stall_request   = 0;
		mismatch_count  = 0;
		tbl_next_id     = 0;
		tbl_live_count  = 0;
		foreach (tbl_live[i])
			tbl_live[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].payload,
				directed_rows[i].known, directed_rows[i].known_rsp);
		wait_drained();

		// Growth: the table fills up part way. Partway through, the receiver stops for a long
		// stretch while requests keep coming, so the output and holding registers both fill
		// and the block has to stop taking requests.
		for (int i = 0; i < GROW_ITEMS; i++) begin
			if (i == GROW_ITEMS / 2)
				stall_request = LONG_STALL;
			issue_random(MIX_GROW);
		end
		// The sender stays quiet until every owed response is back.
		wait_drained();

		// Promotion run: one fresh entry is promoted many times in a row, so that it
		// outranks everything else in the table.
		idling_on = 1'b0;
		issue_request(OP_ADD, ID_W'($urandom_range(ID_MAX, 0)), $urandom(), 1'b0, RSP_ZERO);
		hot_id = ID_W'(tbl_next_id - 1);
		repeat (PROMOTE_BURST)
			issue_request(OP_PROMOTE, hot_id, $urandom(), 1'b0, RSP_ZERO);
		issue_request(OP_QUERY, hot_id, $urandom(), 1'b0, RSP_ZERO);
		wait_drained();

		// Fill: keep adding until ids run out, then go on a while with a full table, so adds
		// are refused and peek and pop scan every slot.
		idling_on = 1'b1;
		while (tbl_next_id < CAPACITY_DEF)
			issue_random(MIX_FILL);
		repeat (FULL_EXTRA)
			issue_random(MIX_FILL);
		wait_drained();

		// Drain, with no idling at all: a pop-heavy mix, then pop until nothing is live, and
		// finish with every operation on an empty, exhausted table.
		idling_on = 1'b0;
		repeat (DRAIN_ITEMS)
			issue_random(MIX_DRAIN);
		while (tbl_live_count != 0)
			issue_request(OP_POP, ID_W'($urandom_range(ID_MAX, 0)), $urandom(), 1'b0, RSP_ZERO);
		issue_request(OP_PEEK, ID_W'($urandom_range(ID_MAX, 0)), $urandom(), 1'b0, RSP_ZERO);
		issue_request(OP_POP, ID_W'($urandom_range(ID_MAX, 0)), $urandom(), 1'b0, RSP_ZERO);
		issue_request(OP_ADD, ID_W'($urandom_range(ID_MAX, 0)), $urandom(), 1'b0, RSP_ZERO);
		issue_request(OP_QUERY, ID_W'($urandom_range(ID_MAX, 0)), $urandom(), 1'b0, RSP_ZERO);
		issue_request(OP_PROMOTE, ID_W'($urandom_range(ID_MAX, 0)), $urandom(), 1'b0,
			RSP_ZERO);
		wait_drained();

		// A full scan is the longest the block can take. Anything that turns up in this
		// window has no request behind it and counts as a failure.
		repeat (CAPACITY_DEF + 40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// This bound allows several times the slowest correct run before the run is declared hung.
	initial begin
		#60_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
